>>> hw/rtl/cpg_pkg.sv
// shared constants and types for the circle point generator
`timescale 1ns / 1ps
`default_nettype none
package cpg_pkg;

    // default coordinate width of the center inputs
    localparam int COORD_BITS_DEF = 10;

    // entries in the step queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // point index within one step, eight mirrored points
    localparam int          IDX_BITS = 3;
    localparam logic [2:0]  LAST_IDX = 3'd7;

    // queue status seen by producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } cpg_q_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/cpg_if.sv
// valid/ready channel interfaces for commands and points
`timescale 1ns / 1ps
`default_nettype none
interface cpg_cmd_if #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [COORD_BITS-1:0]   center_x;
    logic [COORD_BITS-1:0]   center_y;
    logic [COORD_BITS-2:0]   circle_radius;

    modport source (output valid, command, center_x, center_y, circle_radius, input ready);
    modport sink   (input valid, command, center_x, center_y, circle_radius, output ready);
endinterface

interface cpg_pt_if #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [COORD_BITS+1:0] point_x;
    logic signed [COORD_BITS+1:0] point_y;
    logic                        last_of_step;
    logic                        finished;

    modport source (output valid, point_x, point_y, last_of_step, finished, input ready);
    modport sink   (input valid, point_x, point_y, last_of_step, finished, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cpg_queue.sv
// small step queue between the command front and the point back end
`timescale 1ns / 1ps
`default_nettype none
module cpg_queue #(
    parameter int WIDTH = 41,
    parameter int DEPTH = cpg_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output cpg_pkg::cpg_q_stat_t   stat,
    output logic [WIDTH-1:0]       head_data
);
    import cpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("step queue count above depth");

endmodule
`default_nettype wire

>>> hw/rtl/cpg_front.sv
// command front: holds circle state, runs one midpoint step per beat
`timescale 1ns / 1ps
`default_nettype none
module cpg_front #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF,
    parameter int REC_W      = 4 * COORD_BITS + 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    cpg_cmd_if.sink                  cmd,
    input  wire cpg_pkg::cpg_q_stat_t q_stat,
    output logic                     push,
    output logic [REC_W-1:0]         push_data
);
    import cpg_pkg::*;

    localparam int DEC_BITS = COORD_BITS + 3;

    logic [COORD_BITS-1:0]      step_x_reg, step_x_next;
    logic [COORD_BITS-1:0]      step_y_reg, step_y_next;
    logic signed [DEC_BITS-1:0] decision_reg, decision_next;
    logic [COORD_BITS-1:0]      cx_reg, cx_next;
    logic [COORD_BITS-1:0]      cy_reg, cy_next;
    logic                       active_reg, active_next;

    logic                       accept;
    logic                       done;
    logic signed [DEC_BITS-1:0] diff;

    assign cmd.ready = !q_stat.full;
    assign accept    = cmd.valid && cmd.ready;

    // start loads the circle, advance steps x and maybe y
    always_comb
    begin
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        decision_next = decision_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        active_next   = active_reg;
        push          = 1'b0;
        done          = 1'b0;
        diff          = '0;
        if (accept)
        begin
            case (cmd.command)
                CMD_START:
                begin
                    cx_next       = cmd.center_x;
                    cy_next       = cmd.center_y;
                    step_x_next   = '0;
                    step_y_next   = {1'b0, cmd.circle_radius};
                    decision_next = DEC_BITS'(1) - DEC_BITS'(cmd.circle_radius);
                    done          = (cmd.circle_radius == '0);
                    active_next   = !done;
                    push          = 1'b1;
                end
                CMD_ADVANCE:
                begin
                    if (active_reg)
                    begin
                        step_x_next = step_x_reg + 1'b1;
                        if (decision_reg[DEC_BITS-1])
                        begin
                            decision_next = decision_reg
                                          + DEC_BITS'({step_x_next, 1'b1});
                        end
                        else
                        begin
                            step_y_next   = step_y_reg - 1'b1;
                            diff          = DEC_BITS'(step_x_next) - DEC_BITS'(step_y_next);
                            decision_next = decision_reg + (diff <<< 1) + DEC_BITS'(1);
                        end
                        done        = (step_x_next >= step_y_next);
                        active_next = !done;
                        push        = 1'b1;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // step record: finished flag, center, current x and y
    assign push_data = {done, cy_next, cx_next, step_y_next, step_x_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            active_reg   <= active_next;
        end
    end

    a_active_order: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_x_reg < step_y_reg))
        else $error("circle in progress with x not below y");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && done) |=> !active_reg)
        else $error("circle still active after finishing step");

endmodule
`default_nettype wire

>>> hw/rtl/cpg_back.sv
// point back end: expands one step record into eight mirrored points
`timescale 1ns / 1ps
`default_nettype none
module cpg_back #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF,
    parameter int REC_W      = 4 * COORD_BITS + 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cpg_pkg::cpg_q_stat_t q_stat,
    input  wire logic [REC_W-1:0]    head_data,
    output logic                     pop,
    cpg_pt_if.source                 pts
);
    import cpg_pkg::*;

    localparam int PW = COORD_BITS + 2;

    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PW-1:0]         px_reg, px_next;
    logic [PW-1:0]         py_reg, py_next;
    logic                  last_reg;
    logic                  fin_reg;

    logic                  head_valid;
    logic                  load;
    logic [COORD_BITS-1:0] hx, hy, hcx, hcy;
    logic                  hdone;
    logic [PW-1:0]         a_ext, b_ext, cx_ext, cy_ext;

    assign head_valid = !q_stat.empty;
    assign load       = head_valid && (!out_valid_reg || pts.ready);
    assign pop        = load && (idx_reg == LAST_IDX);

    assign {hdone, hcy, hcx, hy, hx} = head_data;

    // first four points use (x, y), last four swap them
    always_comb
    begin
        cx_ext = {2'b00, hcx};
        cy_ext = {2'b00, hcy};
        a_ext  = idx_reg[2] ? {2'b00, hy} : {2'b00, hx};
        b_ext  = idx_reg[2] ? {2'b00, hx} : {2'b00, hy};
        px_next = idx_reg[1] ? (cx_ext - a_ext) : (cx_ext + a_ext);
        py_next = (idx_reg[1] ^ idx_reg[0]) ? (cy_ext - b_ext) : (cy_ext + b_ext);
    end

    always_comb
    begin
        idx_next       = load ? idx_reg + 1'b1 : idx_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !pts.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            last_reg <= (idx_reg == LAST_IDX);
            fin_reg  <= hdone;
        end
    end

    assign pts.valid        = out_valid_reg;
    assign pts.point_x      = px_reg;
    assign pts.point_y      = py_reg;
    assign pts.last_of_step = last_reg;
    assign pts.finished     = fin_reg;

    a_mid_step_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid)
        else $error("step record gone before its eighth point");

endmodule
`default_nettype wire

>>> hw/rtl/circle_point_generator.sv
// top level of the midpoint circle point generator
//
//  channel   dir  carries                                         beat
//  cmd       in   command, center_x, center_y, circle_radius      one command
//  pts       out  point_x, point_y, last_of_step, finished        one point
//
// a start or an active advance yields eight point beats, one per cycle
// unless the output stalls; the point back end sets the pace of a steady
// run of commands. the front takes each command and hands the step to a
// two-entry queue; advances with no circle in progress are taken and
// dropped. reset clears all circle state. a stalled output holds its beat
// while the front keeps taking commands until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module circle_point_generator #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cpg_cmd_if.sink    cmd,
    cpg_pt_if.source   pts
);
    import cpg_pkg::*;

    localparam int REC_W = 4 * COORD_BITS + 1;

    cpg_q_stat_t      q_stat;
    logic             push;
    logic [REC_W-1:0] push_data;
    logic             pop;
    logic [REC_W-1:0] head_data;

    // command front
    cpg_front #(
        .COORD_BITS (COORD_BITS),
        .REC_W      (REC_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // step queue
    cpg_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .stat      (q_stat),
        .head_data (head_data)
    );

    // point back end
    cpg_back #(
        .COORD_BITS (COORD_BITS),
        .REC_W      (REC_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_data (head_data),
        .pop       (pop),
        .pts       (pts)
    );

endmodule
`default_nettype wire
